// ===== hw/rtl/fva_pkg.sv =====
// ----------------------------------------------------------------------------
// fva_pkg: shared types and constants for the FM voice allocator
// Cell command and status words, register bases, F-number table.
// ----------------------------------------------------------------------------
package fva_pkg;

    localparam int VOICE_COUNT_DEF = 9;
    localparam int VPE_DEF         = 3;

    localparam int VW  = 4;   // voice index / rank width
    localparam int CW  = 5;   // key-on order count width (holds 16)
    localparam int MAPW = 16; // playing map width

    // FM chip register bases
    localparam logic [6:0] REG_FNUM = 7'h10;
    localparam logic [6:0] REG_KEY  = 7'h20;
    localparam logic [6:0] REG_INST = 7'h30;

    localparam logic [7:0] KEY_ON_BIT = 8'h10;
    localparam logic [3:0] VOL_MAX    = 4'hf;
    localparam logic [6:0] NOTE_A0    = 7'd9;   // lowest note with interval 0

    typedef enum logic [2:0] {
        OP_IDLE        = 3'd0,
        OP_SCAN_FREE   = 3'd1,
        OP_SCAN_MATCH  = 3'd2,
        OP_SCAN_OLDEST = 3'd3,
        OP_TAKE        = 3'd4,
        OP_FREE        = 3'd5
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_KEY_OFF = 2'd0,
        ST_INST    = 2'd1,
        ST_FNUM    = 2'd2,
        ST_KEY_ON  = 2'd3
    } t_step;

    // broadcast to every voice cell
    typedef struct packed {
        t_cell_op        op;
        logic [6:0]      note;
        logic [3:0]      chan;
        logic [VW-1:0]   voice;     // target cell of take / free
        logic [VW-1:0]   new_rank;  // age rank given to the target on take
        logic [VW-1:0]   cut;       // ranks above this close up
        logic            shift;     // close up ranks on this update
    } t_cell_cmd;

    typedef struct packed {
        logic            hit;
        logic            busy;
        logic [VW-1:0]   rank;
    } t_cell_stat;

    typedef struct packed {
        logic            hit;
        logic [VW-1:0]   rank;      // rank of the hit cell
        logic [MAPW-1:0] busy_map;
    } t_row_stat;

    // floor(150 * 2^((i-9)/12)) for intervals -9..11
    function automatic logic [8:0] fnum_of(input logic [4:0] idx);
        logic [8:0] f;
        begin
            unique case (idx)
                5'd0:    f = 9'd89;
                5'd1:    f = 9'd94;
                5'd2:    f = 9'd100;
                5'd3:    f = 9'd106;
                5'd4:    f = 9'd112;
                5'd5:    f = 9'd119;
                5'd6:    f = 9'd126;
                5'd7:    f = 9'd133;
                5'd8:    f = 9'd141;
                5'd9:    f = 9'd150;
                5'd10:   f = 9'd158;
                5'd11:   f = 9'd168;
                5'd12:   f = 9'd178;
                5'd13:   f = 9'd188;
                5'd14:   f = 9'd200;
                5'd15:   f = 9'd212;
                5'd16:   f = 9'd224;
                5'd17:   f = 9'd238;
                5'd18:   f = 9'd252;
                5'd19:   f = 9'd267;
                5'd20:   f = 9'd283;
                default: f = 9'd0;
            endcase
            return f;
        end
    endfunction

endpackage

// ===== hw/rtl/fva_cell.sv =====
// ----------------------------------------------------------------------------
// fva_cell: one FM voice slot
// Holds note, channel and age rank; passes the scan token to its neighbor.
// ----------------------------------------------------------------------------
module fva_cell #(
    parameter int CELL_ID = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fva_pkg::t_cell_cmd    i_cmd,
    input  logic                  i_tok,
    output logic                  o_tok,
    output fva_pkg::t_cell_stat   o_stat
);

    localparam logic [fva_pkg::VW-1:0] MY_ID = fva_pkg::VW'(CELL_ID);

    logic                    r_busy;
    logic                    r_tok;
    logic [6:0]              r_note;
    logic [3:0]              r_chan;
    logic [fva_pkg::VW-1:0]  r_rank;

    logic is_scan;
    logic cond;
    logic sel;
    logic close_up;

    always_comb begin
        is_scan = 1'b0;
        cond    = 1'b0;
        unique case (i_cmd.op)
            fva_pkg::OP_SCAN_FREE: begin
                is_scan = 1'b1;
                cond    = !r_busy;
            end
            fva_pkg::OP_SCAN_MATCH: begin
                is_scan = 1'b1;
                cond    = r_busy && (r_note == i_cmd.note) && (r_chan == i_cmd.chan);
            end
            fva_pkg::OP_SCAN_OLDEST: begin
                is_scan = 1'b1;
                cond    = r_busy && (r_rank == '0);
            end
            default: begin
                is_scan = 1'b0;
                cond    = 1'b0;
            end
        endcase
    end

    assign sel      = (i_cmd.voice == MY_ID);
    assign close_up = r_busy && i_cmd.shift && (r_rank > i_cmd.cut);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_tok  <= 1'b0;
        end else begin
            r_tok <= is_scan && i_tok;
            if (i_cmd.op == fva_pkg::OP_TAKE && sel) begin
                r_busy <= 1'b1;
            end else if (i_cmd.op == fva_pkg::OP_FREE && sel) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == fva_pkg::OP_TAKE && sel) begin
            r_note <= i_cmd.note;
            r_chan <= i_cmd.chan;
            r_rank <= i_cmd.new_rank;
        end else if ((i_cmd.op == fva_pkg::OP_TAKE || i_cmd.op == fva_pkg::OP_FREE)
                     && close_up) begin
            r_rank <= r_rank - 1'b1;
        end
    end

    assign o_tok       = r_tok;
    assign o_stat.hit  = r_tok && cond;
    assign o_stat.busy = r_busy;
    assign o_stat.rank = r_rank;

endmodule

// ===== hw/rtl/fva_row.sv =====
// ----------------------------------------------------------------------------
// fva_row: the chain of voice cells
// Threads the scan token through the cells and collects their status.
// ----------------------------------------------------------------------------
module fva_row #(
    parameter int VOICE_COUNT = fva_pkg::VOICE_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fva_pkg::t_cell_cmd  i_cmd,
    input  logic                i_kick,
    output fva_pkg::t_row_stat  o_stat
);

    logic [VOICE_COUNT:0]      tok_chain;
    logic [VOICE_COUNT-1:0]    hit_vec;
    fva_pkg::t_cell_stat       cell_stat [VOICE_COUNT];

    assign tok_chain[0] = i_kick;

    for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_cell
        fva_cell #(
            .CELL_ID (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (i_cmd),
            .i_tok   (tok_chain[g]),
            .o_tok   (tok_chain[g+1]),
            .o_stat  (cell_stat[g])
        );
        assign hit_vec[g] = cell_stat[g].hit;
    end

    always_comb begin
        o_stat.hit      = |hit_vec;
        o_stat.rank     = '0;
        o_stat.busy_map = '0;
        for (int i = 0; i < VOICE_COUNT; i++) begin
            if (cell_stat[i].hit) begin
                o_stat.rank = o_stat.rank | cell_stat[i].rank;
            end
            o_stat.busy_map[i] = cell_stat[i].busy;
        end
    end

    // only one token may travel the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_chain[VOICE_COUNT:1]))
        else $error("fva_row: more than one scan token");

    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit_vec))
        else $error("fva_row: several cells hit in one scan");

    // a busy voice's age rank stays inside the key-on order
    for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_chk
        a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            cell_stat[g].busy |-> (int'(cell_stat[g].rank) < VOICE_COUNT))
            else $error("fva_row: busy voice rank out of range");
    end

endmodule

// ===== hw/rtl/fm_voice_allocator.sv =====
// ----------------------------------------------------------------------------
// fm_voice_allocator: MIDI note events to FM chip register writes
// Voice slots in a cell chain, oldest-note steal, register write sequencer.
// ----------------------------------------------------------------------------
// Sequence: load state, token scan of up to VOICE_COUNT cells, update state
//   (none for an unmatched note off), then one result word per cycle while the
//   output is not stalled; a note on that steals runs two scans.
// Events: one at a time; a new event is taken only back in idle.
// Reset (i_rst_n low, synchronous): all voices free, order empty, instrument
//   map back to instrument 1 on every channel, no result pending.
module fm_voice_allocator #(
    parameter int VOICE_COUNT       = fva_pkg::VOICE_COUNT_DEF,
    parameter int VOICES_PER_ENGINE = fva_pkg::VPE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic         i_cfg_we,
    input  logic [63:0]  i_cfg_wdata,
    // event word in
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_action,
    input  logic [6:0]   i_note,
    input  logic [6:0]   i_velocity,
    input  logic [3:0]   i_midi_channel,
    // register write word out
    output logic         o_valid,
    input  logic         i_ready,
    output logic         o_write_valid,
    output logic [3:0]   o_voice_index,
    output logic [2:0]   o_core_index,
    output logic [6:0]   o_reg_addr,
    output logic [7:0]   o_reg_value,
    output logic         o_status,
    output logic [15:0]  o_playing_map,
    output logic         o_last
);

    localparam int VW = fva_pkg::VW;
    localparam int CW = fva_pkg::CW;
    localparam logic [VW-1:0] LAST_VOICE = VW'(VOICE_COUNT - 1);
    localparam logic [63:0]   INST_MAP_RST = 64'h1111_1111_1111_1111;

    // voice -> engine index, built at elaboration by counting
    function automatic logic [15:0][2:0] core_tab_f();
        logic [15:0][2:0] tab;
        int q;
        int r;
        begin
            q = 0;
            r = 0;
            for (int i = 0; i < 16; i++) begin
                tab[i] = 3'(q);
                r = r + 1;
                if (r == VOICES_PER_ENGINE) begin
                    r = 0;
                    q = q + 1;
                end
            end
            return tab;
        end
    endfunction

    localparam logic [15:0][2:0] CORE_TAB = core_tab_f();

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,  // kick the token into cell 0
        S_SCAN = 5'b00100,  // token walks the chain, one cell a cycle
        S_UPD  = 5'b01000,  // take / free, close up the age order
        S_EMIT = 5'b10000   // one result word per cycle unless the output stalls
    } t_state;

    t_state              r_state;
    logic [63:0]         r_inst_map;
    logic [CW-1:0]       r_count;     // voices in the key-on order
    logic [VW-1:0]       r_scan;
    logic [VW-1:0]       r_voice;
    logic [VW-1:0]       r_vrank;
    logic                r_steal;
    logic                r_miss;
    fva_pkg::t_step      r_k;

    // event latch
    logic                r_action;
    logic [6:0]          r_note;
    logic [6:0]          r_vel;
    logic [3:0]          r_chan;
    logic [11:0]         r_bf;        // block << 9 + F-number

    // output register
    logic                r_ovalid;
    logic                r_owv;
    logic [3:0]          r_ovoice;
    logic [2:0]          r_ocore;
    logic [6:0]          r_oaddr;
    logic [7:0]          r_ovalue;
    logic                r_ostatus;
    logic [15:0]         r_omap;
    logic                r_olast;

    fva_pkg::t_cell_cmd  cmd;
    fva_pkg::t_row_stat  row;
    logic                accept;
    logic                load;
    logic                is_last;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign load    = (r_state == S_EMIT) && (!r_ovalid || i_ready);
    assign is_last = r_miss || r_action || (r_k == fva_pkg::ST_KEY_ON);

    // ---------------- cell chain ----------------
    always_comb begin
        cmd.op       = fva_pkg::OP_IDLE;
        cmd.note     = r_note;
        cmd.chan     = r_chan;
        cmd.voice    = r_voice;
        cmd.new_rank = r_steal ? LAST_VOICE : r_count[VW-1:0];
        cmd.cut      = r_vrank;
        cmd.shift    = r_action || r_steal;
        if (r_state == S_LOAD || r_state == S_SCAN) begin
            if (r_steal) begin
                cmd.op = fva_pkg::OP_SCAN_OLDEST;
            end else if (r_action) begin
                cmd.op = fva_pkg::OP_SCAN_MATCH;
            end else begin
                cmd.op = fva_pkg::OP_SCAN_FREE;
            end
        end else if (r_state == S_UPD) begin
            cmd.op = r_action ? fva_pkg::OP_FREE : fva_pkg::OP_TAKE;
        end
    end

    fva_row #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_kick  (r_state == S_LOAD),
        .o_stat  (row)
    );

    // ---------------- block and F-number ----------------
    // (note-9)/12 by reciprocal 171/2048, exact below 512
    logic [6:0]  semi;
    logic [14:0] q_prod;
    logic [3:0]  oct;
    logic [6:0]  oct12;
    logic [3:0]  rem;
    logic [4:0]  fidx;
    logic [2:0]  block;

    always_comb begin
        semi   = r_note - fva_pkg::NOTE_A0;
        q_prod = 15'(semi) * 15'd171;
        oct    = q_prod[14:11];
        oct12  = 7'(oct) * 7'd12;
        rem    = 4'(semi - oct12);
        if (r_note < fva_pkg::NOTE_A0) begin
            fidx  = r_note[4:0];
            block = 3'd0;
        end else begin
            fidx  = 5'd9 + 5'(rem);
            block = (oct > 4'd7) ? 3'd7 : oct[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_bf <= {block, 9'd0} + 12'(fva_pkg::fnum_of(fidx));
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inst_map <= INST_MAP_RST;
        end else if (i_cfg_we) begin
            r_inst_map <= i_cfg_wdata;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_steal <= 1'b0;
            r_miss  <= 1'b0;
            r_scan  <= '0;
            r_k     <= fva_pkg::ST_KEY_OFF;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_steal <= 1'b0;
                        r_miss  <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_scan  <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (row.hit) begin
                        r_state <= S_UPD;
                    end else if (r_scan == LAST_VOICE) begin
                        if (r_action) begin
                            // note off with no matching voice
                            r_miss  <= 1'b1;
                            r_k     <= fva_pkg::ST_KEY_OFF;
                            r_state <= S_EMIT;
                        end else begin
                            // all busy: rescan for the oldest voice
                            r_steal <= 1'b1;
                            r_state <= S_LOAD;
                        end
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_UPD: begin
                    if (r_action) begin
                        r_count <= r_count - 1'b1;
                    end else if (!r_steal) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_k     <= (r_action || r_steal) ? fva_pkg::ST_KEY_OFF
                                                     : fva_pkg::ST_INST;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (load) begin
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= fva_pkg::t_step'(r_k + 1'b1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_note   <= i_note;
            r_vel    <= i_velocity;
            r_chan   <= i_midi_channel;
        end
        if (r_state == S_SCAN && row.hit) begin
            r_voice <= r_scan;
            r_vrank <= row.rank;
        end
    end

    // ---------------- result word ----------------
    logic [3:0] inst;
    logic [3:0] vol;
    logic [6:0] n_addr;
    logic [7:0] n_value;

    assign inst = r_inst_map[{r_chan, 2'b00} +: 4];
    assign vol  = fva_pkg::VOL_MAX - r_vel[6:3];

    always_comb begin
        unique case (r_k)
            fva_pkg::ST_KEY_OFF: begin
                n_addr  = fva_pkg::REG_KEY + 7'(r_voice);
                n_value = 8'd0;
            end
            fva_pkg::ST_INST: begin
                n_addr  = fva_pkg::REG_INST + 7'(r_voice);
                n_value = {inst, vol};
            end
            fva_pkg::ST_FNUM: begin
                n_addr  = fva_pkg::REG_FNUM + 7'(r_voice);
                n_value = r_bf[7:0];
            end
            fva_pkg::ST_KEY_ON: begin
                n_addr  = fva_pkg::REG_KEY + 7'(r_voice);
                n_value = fva_pkg::KEY_ON_BIT + {4'd0, r_bf[11:8]};
            end
            default: begin
                n_addr  = '0;
                n_value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_omap  <= row.busy_map;
            r_olast <= is_last;
            if (r_miss) begin
                r_owv     <= 1'b0;
                r_ovoice  <= '0;
                r_ocore   <= '0;
                r_oaddr   <= '0;
                r_ovalue  <= '0;
                r_ostatus <= 1'b1;
            end else begin
                r_owv     <= 1'b1;
                r_ovoice  <= r_voice;
                r_ocore   <= CORE_TAB[r_voice];
                r_oaddr   <= n_addr;
                r_ovalue  <= n_value;
                r_ostatus <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_write_valid = r_owv;
    assign o_voice_index = r_ovoice;
    assign o_core_index  = r_ocore;
    assign o_reg_addr    = r_oaddr;
    assign o_reg_value   = r_ovalue;
    assign o_status      = r_ostatus;
    assign o_playing_map = r_omap;
    assign o_last        = r_olast;

    // ---------------- checks ----------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= VOICE_COUNT)
        else $error("fm_voice_allocator: key-on order count overflow");

    // between events the order holds exactly the busy voices
    a_count_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(row.busy_map) == int'(r_count)))
        else $error("fm_voice_allocator: order count differs from busy voices");

    // a steal only happens with every voice busy
    a_steal_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_steal) |-> (int'(r_count) == VOICE_COUNT))
        else $error("fm_voice_allocator: steal with a free voice");

endmodule
